[design/gmps_pkg.sv]
// ----------------------------------------------------------------------------
// gmps_pkg: shared definitions for the grid maze path search
// Field widths, direction and register codes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package gmps_pkg;

  localparam int unsigned MaxDimDef = 8;
  localparam int unsigned CoordW    = 3;
  localparam int unsigned DimW      = 4;
  localparam int unsigned DirW      = 3;
  localparam int unsigned CfgIdxW   = 1;

  localparam logic [DimW-1:0] DimReset = 4'd8;

  localparam logic [DirW-1:0] DirDown  = 3'd0;
  localparam logic [DirW-1:0] DirRight = 3'd1;
  localparam logic [DirW-1:0] DirUp    = 3'd2;
  localparam logic [DirW-1:0] DirLeft  = 3'd3;
  localparam logic [DirW-1:0] DirDone  = 3'd4;

  localparam logic KindLoad   = 1'b0;
  localparam logic KindSearch = 1'b1;

  localparam logic [CfgIdxW-1:0] CfgRowCount = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgColCount = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START_CHK,
    S_STEP,
    S_CHECK,
    S_POP_WAIT,
    S_EMIT_TOP,
    S_EMIT_STACK,
    S_NOT_FOUND,
    S_SAME
  } gmps_state_e;

  typedef struct packed {
    logic load_cell;
    logic search_start;
    logic step;
    logic push;
    logic pop;
    logic pop_load;
    logic emit_top;
    logic emit_stack;
    logic emit_none;
    logic emit_same;
  } gmps_cmd_t;

  typedef struct packed {
    logic start_is_goal;
    logic nbr_is_goal;
    logic can_enter;
    logic dir_done;
    logic depth_one;
    logic out_free;
  } gmps_stat_t;

endpackage

[design/gmps_ctrl.sv]
// ----------------------------------------------------------------------------
// gmps_ctrl: search sequencer
// State machine that steps the depth-first walk, backtracks and drives the
// path words out through the datapath.
// ----------------------------------------------------------------------------
module gmps_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_kind_i,
  input  gmps_pkg::gmps_stat_t stat_i,
  output logic                in_stall_o,
  output gmps_pkg::gmps_cmd_t cmd_o
);
  import gmps_pkg::*;

  gmps_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (in_kind_i == KindSearch) begin
            cmd_o.search_start = 1'b1;
            state_d = stat_i.start_is_goal ? S_SAME : S_START_CHK;
          end else begin
            cmd_o.load_cell = 1'b1;
          end
        end
      end
      S_START_CHK: begin
        if (stat_i.can_enter) begin
          cmd_o.push = 1'b1;
          state_d = S_STEP;
        end else begin
          state_d = S_NOT_FOUND;
        end
      end
      S_STEP: begin
        if (stat_i.dir_done) begin
          if (stat_i.depth_one) begin
            state_d = S_NOT_FOUND;
          end else begin
            cmd_o.pop = 1'b1;
            state_d = S_POP_WAIT;
          end
        end else begin
          cmd_o.step = 1'b1;
          state_d = stat_i.nbr_is_goal ? S_EMIT_TOP : S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.push = stat_i.can_enter;
        state_d = S_STEP;
      end
      S_POP_WAIT: begin
        cmd_o.pop_load = 1'b1;
        state_d = S_STEP;
      end
      S_EMIT_TOP: begin
        if (stat_i.out_free) begin
          cmd_o.emit_top = 1'b1;
          state_d = stat_i.depth_one ? S_IDLE : S_EMIT_STACK;
        end
      end
      S_EMIT_STACK: begin
        if (stat_i.out_free) begin
          cmd_o.emit_stack = 1'b1;
          if (stat_i.depth_one) begin
            state_d = S_IDLE;
          end
        end
      end
      S_NOT_FOUND: begin
        if (stat_i.out_free) begin
          cmd_o.emit_none = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_SAME: begin
        if (stat_i.out_free) begin
          cmd_o.emit_same = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

[design/gmps_dpath.sv]
// ----------------------------------------------------------------------------
// gmps_dpath: search datapath
// Maze memory, visited marks, search stack memory, top-of-stack registers,
// neighbour generation and the output word register.
// ----------------------------------------------------------------------------
module gmps_dpath #(
  parameter int unsigned MAX_DIM = gmps_pkg::MaxDimDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gmps_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [gmps_pkg::DimW-1:0]     cfg_data_i,
  input  logic [gmps_pkg::CoordW-1:0]   in_row_i,
  input  logic [gmps_pkg::CoordW-1:0]   in_col_i,
  input  logic                          in_cell_open_i,
  input  logic [gmps_pkg::CoordW-1:0]   in_goal_row_i,
  input  logic [gmps_pkg::CoordW-1:0]   in_goal_col_i,
  input  gmps_pkg::gmps_cmd_t           cmd_i,
  output gmps_pkg::gmps_stat_t          stat_o,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic                          out_found_o,
  output logic                          out_has_cell_o,
  output logic [gmps_pkg::CoordW-1:0]   out_cell_row_o,
  output logic [gmps_pkg::CoordW-1:0]   out_cell_col_o,
  output logic                          out_last_o
);
  import gmps_pkg::*;

  localparam int unsigned Cells  = MAX_DIM * MAX_DIM;
  localparam int unsigned IdxW   = $clog2(Cells);
  localparam int unsigned DepthW = $clog2(Cells + 1);
  localparam int unsigned EntryW = 2 * CoordW + DirW;
  localparam logic [DimW-1:0] MaxDimV = DimW'(MAX_DIM);

  function automatic logic [IdxW-1:0] cell_idx(logic [DimW-1:0] r, logic [DimW-1:0] c);
    logic [7:0] full;
    full = 8'(r) * 8'(MAX_DIM) + 8'(c);
    return full[IdxW-1:0];
  endfunction

  logic [DimW-1:0]   row_count_q, col_count_q;
  logic [CoordW-1:0] goal_r_q, goal_c_q;
  logic [CoordW-1:0] top_r_q, top_c_q;
  logic [DirW-1:0]   top_dir_q;
  logic [DimW-1:0]   nbr_r_q, nbr_c_q;
  logic [DepthW-1:0] depth_q;
  logic [Cells-1:0]  visited_q;
  logic              maze_q [Cells];
  logic              maze_rd_q;
  logic [EntryW-1:0] stack_q [Cells];
  logic [EntryW-1:0] stack_rd_q;
  logic              out_valid_q, out_found_q, out_has_cell_q, out_last_q;
  logic [CoordW-1:0] out_row_q, out_col_q;

  logic [DimW-1:0]   eff_rows, eff_cols;
  logic [DimW-1:0]   step_r, step_c;
  logic [DimW-1:0]   in_r4, in_c4;
  logic [IdxW-1:0]   maze_rd_idx, nbr_idx;
  logic              maze_rd_en, load_ok, stack_rd_en, out_load, emit_any;
  logic [DepthW-1:0] depth_m1, depth_m2;

  assign eff_rows = (row_count_q > MaxDimV) ? MaxDimV : row_count_q;
  assign eff_cols = (col_count_q > MaxDimV) ? MaxDimV : col_count_q;
  assign in_r4    = {1'b0, in_row_i};
  assign in_c4    = {1'b0, in_col_i};

  always_comb begin
    step_r = {1'b0, top_r_q};
    step_c = {1'b0, top_c_q};
    case (top_dir_q)
      DirDown:  step_r = {1'b0, top_r_q} + 4'd1;
      DirRight: step_c = {1'b0, top_c_q} + 4'd1;
      DirUp:    step_r = {1'b0, top_r_q} - 4'd1;
      DirLeft:  step_c = {1'b0, top_c_q} - 4'd1;
      default: ;
    endcase
  end

  assign maze_rd_en  = cmd_i.search_start | cmd_i.step;
  assign maze_rd_idx = cmd_i.search_start ? cell_idx(in_r4, in_c4) : cell_idx(step_r, step_c);
  assign nbr_idx     = cell_idx(nbr_r_q, nbr_c_q);
  assign load_ok     = cmd_i.load_cell && (in_r4 < MaxDimV) && (in_c4 < MaxDimV);
  assign depth_m1    = depth_q - DepthW'(1);
  assign depth_m2    = depth_q - DepthW'(2);
  assign emit_any    = cmd_i.emit_top | cmd_i.emit_stack;
  assign stack_rd_en = cmd_i.pop | (emit_any & ~stat_o.depth_one);
  assign out_load    = emit_any | cmd_i.emit_none | cmd_i.emit_same;

  assign stat_o.start_is_goal = (in_row_i == in_goal_row_i) && (in_col_i == in_goal_col_i);
  assign stat_o.nbr_is_goal   = (step_r == {1'b0, goal_r_q}) && (step_c == {1'b0, goal_c_q});
  assign stat_o.can_enter     = (nbr_r_q < eff_rows) && (nbr_c_q < eff_cols) && maze_rd_q
                                && !visited_q[nbr_idx];
  assign stat_o.dir_done      = (top_dir_q == DirDone);
  assign stat_o.depth_one     = (depth_q == DepthW'(1));
  assign stat_o.out_free      = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (load_ok) begin
      maze_q[cell_idx(in_r4, in_c4)] <= in_cell_open_i;
    end
    if (maze_rd_en) begin
      maze_rd_q <= maze_q[maze_rd_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push && (depth_q != '0)) begin
      stack_q[depth_m1[IdxW-1:0]] <= {top_r_q, top_c_q, top_dir_q};
    end
    if (stack_rd_en) begin
      stack_rd_q <= stack_q[depth_m2[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.search_start) begin
      goal_r_q <= in_goal_row_i;
      goal_c_q <= in_goal_col_i;
      nbr_r_q  <= in_r4;
      nbr_c_q  <= in_c4;
    end
    if (cmd_i.step) begin
      nbr_r_q   <= step_r;
      nbr_c_q   <= step_c;
      top_dir_q <= top_dir_q + DirW'(1);
    end
    if (cmd_i.push) begin
      top_r_q   <= nbr_r_q[CoordW-1:0];
      top_c_q   <= nbr_c_q[CoordW-1:0];
      top_dir_q <= DirDown;
    end
    if (cmd_i.pop_load) begin
      {top_r_q, top_c_q, top_dir_q} <= stack_rd_q;
    end
    if (cmd_i.emit_top) begin
      out_found_q    <= 1'b1;
      out_has_cell_q <= 1'b1;
      out_row_q      <= top_r_q;
      out_col_q      <= top_c_q;
      out_last_q     <= stat_o.depth_one;
    end
    if (cmd_i.emit_stack) begin
      out_found_q    <= 1'b1;
      out_has_cell_q <= 1'b1;
      out_row_q      <= stack_rd_q[EntryW-1 -: CoordW];
      out_col_q      <= stack_rd_q[DirW +: CoordW];
      out_last_q     <= stat_o.depth_one;
    end
    if (cmd_i.emit_none || cmd_i.emit_same) begin
      out_found_q    <= cmd_i.emit_same;
      out_has_cell_q <= 1'b0;
      out_row_q      <= '0;
      out_col_q      <= '0;
      out_last_q     <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= DimReset;
      col_count_q <= DimReset;
      depth_q     <= '0;
      visited_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgRowCount: row_count_q <= cfg_data_i;
          CfgColCount: col_count_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.search_start) begin
        depth_q   <= '0;
        visited_q <= '0;
      end
      if (cmd_i.push) begin
        depth_q            <= depth_q + DepthW'(1);
        visited_q[nbr_idx] <= 1'b1;
      end
      if (cmd_i.pop || (emit_any && !stat_o.depth_one)) begin
        depth_q <= depth_m1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_found_o    = out_found_q;
  assign out_has_cell_o = out_has_cell_q;
  assign out_cell_row_o = out_row_q;
  assign out_cell_col_o = out_col_q;
  assign out_last_o     = out_last_q;

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DepthW'(Cells))
    else $error("stack depth beyond cell count");

  a_push_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |=> visited_q[$past(nbr_idx)])
    else $error("entered cell not marked visited");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> depth_q > DepthW'(1))
    else $error("pop below stack bottom");

  a_cell_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_has_cell_q) |-> out_found_q)
    else $error("path word without found flag");

endmodule

[design/grid_maze_path_search.sv]
// ----------------------------------------------------------------------------
// grid_maze_path_search: depth-first maze solver
// Holds a grid of open and wall cells, walks it depth first from a start
// cell and returns the path from the goal's predecessor back to the start.
//
//   channel  dir  handshake              words
//   in       in   in_valid_i/in_stall_o  cell load or search request
//   out      out  out_valid_o/out_stall_i one path cell, or a single status word
//   cfg      in   cfg_we_i               row_count (0), col_count (1)
//
// Cell loads may follow back to back.
// A search tries each neighbour by a maze memory read and then a check, and
// backtracks by a stack memory read; then it sends the path words out.
// Reset clears the controller, stack depth, visited marks and output valid flag,
// and sets both counts to 8. A stalled output word holds; emitting waits until the output slot frees.
// ----------------------------------------------------------------------------
module grid_maze_path_search #(
  parameter int unsigned MAX_DIM = gmps_pkg::MaxDimDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gmps_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [gmps_pkg::DimW-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          in_kind_i,
  input  logic [gmps_pkg::CoordW-1:0]   in_row_i,
  input  logic [gmps_pkg::CoordW-1:0]   in_col_i,
  input  logic                          in_cell_open_i,
  input  logic [gmps_pkg::CoordW-1:0]   in_goal_row_i,
  input  logic [gmps_pkg::CoordW-1:0]   in_goal_col_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          out_found_o,
  output logic                          out_has_cell_o,
  output logic [gmps_pkg::CoordW-1:0]   out_cell_row_o,
  output logic [gmps_pkg::CoordW-1:0]   out_cell_col_o,
  output logic                          out_last_o
);
  import gmps_pkg::*;

  gmps_cmd_t  cmd;
  gmps_stat_t stat;

  gmps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_kind_i),
    .stat_i     (stat),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  gmps_dpath #(
    .MAX_DIM (MAX_DIM)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_row_i       (in_row_i),
    .in_col_i       (in_col_i),
    .in_cell_open_i (in_cell_open_i),
    .in_goal_row_i  (in_goal_row_i),
    .in_goal_col_i  (in_goal_col_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .out_found_o    (out_found_o),
    .out_has_cell_o (out_has_cell_o),
    .out_cell_row_o (out_cell_row_o),
    .out_cell_col_o (out_cell_col_o),
    .out_last_o     (out_last_o)
  );

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for grid_maze_path_search
// Fills the whole maze, walks the corner cases of the search, sweeps the used
// area through small, zero, oversized and full settings, and then drives
// random loads and searches. Each search is solved here by an independent
// depth-first walk, and every output word is checked against that walk.
// ----------------------------------------------------------------------------
module tb;
  import gmps_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned Cells      = MaxDimDef * MaxDimDef;

  typedef struct packed {
    logic              found;
    logic              has_cell;
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    logic              last;
  } path_word_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [DimW-1:0]    cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               in_kind_i = 1'b0;
  logic [CoordW-1:0]  in_row_i = '0;
  logic [CoordW-1:0]  in_col_i = '0;
  logic               in_cell_open_i = 1'b0;
  logic [CoordW-1:0]  in_goal_row_i = '0;
  logic [CoordW-1:0]  in_goal_col_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               out_found_o;
  logic               out_has_cell_o;
  logic [CoordW-1:0]  out_cell_row_o;
  logic [CoordW-1:0]  out_cell_col_o;
  logic               out_last_o;

  logic        maze_q [Cells];
  logic        seen_q [Cells];
  logic [DimW-1:0] rows_q = DimReset;
  logic [DimW-1:0] cols_q = DimReset;
  path_word_t  path_words_q [$];
  path_word_t  want;
  logic        steady = 1'b0;
  int          errors = 0;
  int unsigned cycles = 0;

  grid_maze_path_search dut (.*);

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(negedge clk_i) out_stall_i <= !steady && ($urandom_range(99) < 28);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      if (path_words_q.size() == 0) begin
        $error("unexpected word: found %0d has_cell %0d row %0d col %0d last %0d",
               out_found_o, out_has_cell_o, out_cell_row_o, out_cell_col_o, out_last_o);
        errors++;
      end else begin
        want = path_words_q.pop_front();
        if (out_found_o !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_found_o);
          errors++;
        end
        if (out_has_cell_o !== want.has_cell) begin
          $error("has_cell: expected %0d, got %0d", want.has_cell, out_has_cell_o);
          errors++;
        end
        if (out_cell_row_o !== want.row) begin
          $error("cell_row: expected %0d, got %0d", want.row, out_cell_row_o);
          errors++;
        end
        if (out_cell_col_o !== want.col) begin
          $error("cell_col: expected %0d, got %0d", want.col, out_cell_col_o);
          errors++;
        end
        if (out_last_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_last_o);
          errors++;
        end
      end
    end
  end

  function automatic bit enterable(int r, int c, int rlim, int clim);
    return r >= 0 && c >= 0 && r < rlim && c < clim &&
           maze_q[r * MaxDimDef + c] && !seen_q[r * MaxDimDef + c];
  endfunction

  function automatic void solve_maze(logic [CoordW-1:0] sr, logic [CoordW-1:0] sc,
                                     logic [CoordW-1:0] gr, logic [CoordW-1:0] gc);
    logic [CoordW-1:0] st_row [Cells];
    logic [CoordW-1:0] st_col [Cells];
    logic [DirW-1:0]   st_dir [Cells];
    int depth, nr, nc, rlim, clim;
    rlim = (int'(rows_q) > int'(MaxDimDef)) ? int'(MaxDimDef) : int'(rows_q);
    clim = (int'(cols_q) > int'(MaxDimDef)) ? int'(MaxDimDef) : int'(cols_q);
    if (sr == gr && sc == gc) begin
      path_words_q.push_back(path_word_t'{1'b1, 1'b0, 3'd0, 3'd0, 1'b1});
      return;
    end
    foreach (seen_q[i]) seen_q[i] = 1'b0;
    depth = 0;
    if (enterable(int'(sr), int'(sc), rlim, clim)) begin
      seen_q[{sr, sc}] = 1'b1;
      st_row[0] = sr;
      st_col[0] = sc;
      st_dir[0] = DirDown;
      depth = 1;
    end
    while (depth > 0) begin
      if (st_dir[depth-1] == DirDone) begin
        depth--;
      end else begin
        nr = int'(st_row[depth-1]);
        nc = int'(st_col[depth-1]);
        case (st_dir[depth-1])
          DirDown:  nr++;
          DirRight: nc++;
          DirUp:    nr--;
          default:  nc--;
        endcase
        st_dir[depth-1]++;
        if (nr == int'(gr) && nc == int'(gc)) begin
          for (int i = depth - 1; i >= 0; i--)
            path_words_q.push_back(path_word_t'{1'b1, 1'b1, st_row[i], st_col[i], i == 0});
          return;
        end
        if (enterable(nr, nc, rlim, clim) && depth < Cells) begin
          seen_q[nr * MaxDimDef + nc] = 1'b1;
          st_row[depth] = CoordW'(nr);
          st_col[depth] = CoordW'(nc);
          st_dir[depth] = DirDown;
          depth++;
        end
      end
    end
    path_words_q.push_back(path_word_t'{1'b0, 1'b0, 3'd0, 3'd0, 1'b1});
  endfunction

  task automatic send_word(logic kind, logic [CoordW-1:0] row, logic [CoordW-1:0] col,
                           logic open, logic [CoordW-1:0] grow, logic [CoordW-1:0] gcol);
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < 28) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    in_kind_i      <= kind;
    in_row_i       <= row;
    in_col_i       <= col;
    in_cell_open_i <= open;
    in_goal_row_i  <= grow;
    in_goal_col_i  <= gcol;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (kind == KindLoad) maze_q[{row, col}] = open;
    else solve_maze(row, col, grow, gcol);
  endtask

  task automatic wait_results_done(int settle);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (path_words_q.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [DimW-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CfgRowCount: rows_q = value;
      default:     cols_q = value;
    endcase
  endtask

  task automatic set_dims(logic [DimW-1:0] rows, logic [DimW-1:0] cols);
    wait_results_done(8);
    write_reg(CfgRowCount, rows);
    write_reg(CfgColCount, cols);
  endtask

  function automatic logic [CoordW-1:0] pick_coord(logic [DimW-1:0] dim);
    int lim;
    lim = (int'(dim) > int'(MaxDimDef)) ? int'(MaxDimDef) : int'(dim);
    if (lim == 0 || $urandom_range(4) == 0) return CoordW'($urandom_range(7));
    return CoordW'($urandom_range(lim - 1));
  endfunction

  task automatic random_item(int load_pct);
    if ($urandom_range(99) < load_pct)
      send_word(KindLoad, CoordW'($urandom_range(7)), CoordW'($urandom_range(7)),
                $urandom_range(99) < 65, CoordW'($urandom_range(7)),
                CoordW'($urandom_range(7)));
    else
      send_word(KindSearch, pick_coord(rows_q), pick_coord(cols_q), 1'($urandom_range(1)),
                pick_coord(rows_q), pick_coord(cols_q));
  endtask

  task automatic test_load_maze();
    for (int r = 0; r < MaxDimDef; r++)
      for (int c = 0; c < MaxDimDef; c++)
        send_word(KindLoad, CoordW'(r), CoordW'(c), $urandom_range(99) < 70,
                  CoordW'($urandom_range(7)), CoordW'($urandom_range(7)));
  endtask

  task automatic test_corner_cases();
    send_word(KindSearch, 3'd0, 3'd0, 1'b0, 3'd0, 3'd0);
    send_word(KindSearch, 3'd7, 3'd7, 1'b1, 3'd7, 3'd7);
    send_word(KindLoad,   3'd3, 3'd3, 1'b0, 3'd7, 3'd0);
    send_word(KindSearch, 3'd3, 3'd3, 1'b1, 3'd6, 3'd6);
    send_word(KindLoad,   3'd3, 3'd4, 1'b1, 3'd0, 3'd7);
    send_word(KindLoad,   3'd4, 3'd4, 1'b0, 3'd5, 3'd5);
    send_word(KindSearch, 3'd3, 3'd4, 1'b0, 3'd4, 3'd4);
    send_word(KindLoad,   3'd0, 3'd0, 1'b1, 3'd2, 3'd2);
    send_word(KindLoad,   3'd0, 3'd1, 1'b0, 3'd7, 3'd7);
    send_word(KindLoad,   3'd1, 3'd0, 1'b0, 3'd0, 3'd0);
    send_word(KindSearch, 3'd0, 3'd0, 1'b1, 3'd7, 3'd7);
    send_word(KindSearch, 3'd0, 3'd0, 1'b0, 3'd0, 3'd1);
    send_word(KindSearch, 3'd7, 3'd7, 1'b0, 3'd0, 3'd0);
    send_word(KindSearch, 3'd7, 3'd6, 1'b1, 3'd7, 3'd7);
    // goal just outside a one-cell area
    set_dims(4'd1, 4'd1);
    send_word(KindSearch, 3'd0, 3'd0, 1'b0, 3'd1, 3'd0);
    send_word(KindSearch, 3'd0, 3'd0, 1'b1, 3'd0, 3'd1);
    send_word(KindSearch, 3'd0, 3'd1, 1'b0, 3'd0, 3'd0);
  endtask

  task automatic test_dimension_sweep();
    logic [DimW-1:0] row_set [8] = '{4'd1, 4'd0, 4'd5, 4'd15, 4'd8, 4'd2, 4'd8, 4'd3};
    logic [DimW-1:0] col_set [8] = '{4'd1, 4'd5, 4'd0, 4'd15, 4'd8, 4'd8, 4'd1, 4'd4};
    for (int i = 0; i < 8; i++) begin
      set_dims(row_set[i], col_set[i]);
      repeat (7) random_item(15);
    end
  endtask

  task automatic test_random_walks();
    set_dims(4'd8, 4'd8);
    repeat (40) random_item(25);
    steady = 1'b1;
    repeat (40) random_item(25);
    steady = 1'b0;
    // hold the sender until the solver has drained
    wait_results_done(0);
    repeat (25) random_item(25);
    set_dims(DimW'($urandom_range(15)), DimW'($urandom_range(15)));
    repeat (20) random_item(20);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_load_maze();
    test_corner_cases();
    test_dimension_sweep();
    test_random_walks();
    wait_results_done(64);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
